FILE: design/assert_macros.svh
// Assertion macros used by the classifier top level.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// A condition that must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/tfmc_pkg.sv
// Package for the ternary first-match classifier: widths, codes and the
// structs carried along the cell chain. It depends on nothing else.
`default_nettype none

package tfmc_pkg;

  localparam int WORD_W    = 32;  // width of value, care and packet fields
  localparam int ID_W      = 7;   // width of a rule number
  localparam int CNT_W     = 7;   // width of the rule_count register
  localparam int IDX_W     = 6;   // width of entry_index
  localparam int APB_W     = 32;  // configuration data width
  localparam int ADDR_W    = 2;   // configuration address width

  localparam int RULES_DEF = 64;
  localparam int WIDTH_DEF = 32;

  localparam logic [ADDR_W-1:0] ADDR_RULE_COUNT = '0;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_e;

  // Search token handed from one cell to the next.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] packet;
  } token_t;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] care;
    logic [ID_W-1:0]   id;
  } load_t;

endpackage

`default_nettype wire

FILE: design/tfmc_cell.sv
// One cell of the classifier chain: holds a single ternary entry and
// compares the passing search token with it. Depends on tfmc_pkg.
`default_nettype none

module tfmc_cell #(
  parameter int INDEX = 0,
  parameter int VAL_W = tfmc_pkg::WORD_W
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        advance_i,
  input  wire tfmc_pkg::load_t             load_i,
  input  wire logic [tfmc_pkg::CNT_W-1:0]  count_i,
  input  wire tfmc_pkg::token_t            tok_i,
  output tfmc_pkg::token_t                 tok_o
);

  logic [VAL_W-1:0]          value_q;
  logic [VAL_W-1:0]          care_q;
  logic [tfmc_pkg::ID_W-1:0] id_q;
  logic                      sel;
  logic                      active;
  logic                      hit;
  tfmc_pkg::token_t          tok_d;
  tfmc_pkg::token_t          tok_q;

  assign sel    = load_i.en && (32'(load_i.index) == 32'(INDEX));
  assign active = 32'(count_i) > 32'(INDEX);
  assign hit    = tok_i.valid && !tok_i.found && active &&
                  (((value_q ^ tok_i.packet[VAL_W-1:0]) & care_q) == '0);

  // The table entry itself has no reset; it is undefined until loaded.
  always_ff @(posedge clk_i) begin
    if (sel) begin
      value_q <= load_i.value[VAL_W-1:0];
      care_q  <= load_i.care[VAL_W-1:0];
      id_q    <= load_i.id;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.id    = id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: design/ternary_first_match_classifier_top.sv
// Ternary first-match classifier. A classify request walks a chain of RULES
// cells, one cell per clock while the chain advances, each cell holding one
// table entry; the first in-use entry whose cared bits equal the packet
// marks the token, and the result is registered after the last cell. Classify
// requests may be issued every cycle while in_stall_o is low, so the chain
// holds up to RULES searches at once. A load request writes its entry when it
// is taken, but is only taken once the chain has drained, so a load that
// follows a classify waits until that search has left the last cell, longer
// while the result is stalled. When the result register is stalled the whole
// chain holds. No clearing pass follows reset. Depends on tfmc_pkg, tfmc_cell.
`default_nettype none

`include "assert_macros.svh"

module ternary_first_match_classifier_top #(
  parameter int RULES = tfmc_pkg::RULES_DEF,
  parameter int WIDTH = tfmc_pkg::WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tfmc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [tfmc_pkg::APB_W-1:0]    pwdata,
  output logic [tfmc_pkg::APB_W-1:0]         prdata,
  output logic                               pready,

  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          operation_i,
  input  wire logic [tfmc_pkg::IDX_W-1:0]    entry_index_i,
  input  wire logic [tfmc_pkg::WORD_W-1:0]   rule_value_i,
  input  wire logic [tfmc_pkg::WORD_W-1:0]   rule_care_i,
  input  wire logic [tfmc_pkg::ID_W-1:0]     rule_number_i,
  input  wire logic [tfmc_pkg::WORD_W-1:0]   packet_bits_i,

  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tfmc_pkg::ID_W-1:0]          match_number_o,
  output logic                               matched_o
);

  localparam int VAL_W = (WIDTH < tfmc_pkg::WORD_W) ? WIDTH : tfmc_pkg::WORD_W;

  logic [tfmc_pkg::CNT_W-1:0] count_q;
  logic                       cfg_wr;
  logic                       advance;
  logic                       busy;
  logic                       in_accept;
  logic [RULES-1:0]           busy_vec;
  tfmc_pkg::load_t            load;
  tfmc_pkg::token_t           tok [RULES+1];
  logic [31:0]                count_sat;
  logic [31:0]                miss_wide;
  logic [tfmc_pkg::ID_W-1:0]  miss_num;
  logic                       out_valid_q;
  logic [tfmc_pkg::ID_W-1:0]  out_num_q;
  logic                       out_matched_q;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == tfmc_pkg::ADDR_RULE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_wr) begin
      count_q <= pwdata[tfmc_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == tfmc_pkg::ADDR_RULE_COUNT) begin
      prdata = {{(tfmc_pkg::APB_W-tfmc_pkg::CNT_W){1'b0}}, count_q};
    end
  end

  // The chain moves whenever the result register is free or being emptied.
  assign advance    = !out_valid_q || !out_stall_i;
  assign busy       = |busy_vec;
  assign in_stall_o = !advance ||
                      ((operation_i == tfmc_pkg::OP_LOAD) && busy);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    load.en    = in_accept && (operation_i == tfmc_pkg::OP_LOAD);
    load.index = entry_index_i;
    load.value = rule_value_i;
    load.care  = rule_care_i;
    load.id    = rule_number_i;
  end

  assign tok[0] = '{valid:  in_accept && (operation_i == tfmc_pkg::OP_CLASSIFY),
                    found:  1'b0,
                    id:     '0,
                    packet: packet_bits_i};

  for (genvar k = 0; k < RULES; k++) begin : g_cell
    tfmc_cell #(
      .INDEX (k),
      .VAL_W (VAL_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .load_i    (load),
      .count_i   (count_q),
      .tok_i     (tok[k]),
      .tok_o     (tok[k+1])
    );
    assign busy_vec[k] = tok[k+1].valid;
  end

  // Miss value: the searched count, saturated at the table size, plus one.
  assign count_sat = (32'(count_q) > 32'(RULES)) ? 32'(RULES) : 32'(count_q);
  assign miss_wide = count_sat + 32'd1;
  assign miss_num  = miss_wide[tfmc_pkg::ID_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= tok[RULES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && tok[RULES].valid) begin
      out_matched_q <= tok[RULES].found;
      out_num_q     <= tok[RULES].found ? tok[RULES].id : miss_num;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_number_o = out_num_q;
  assign matched_o      = out_matched_q;

  // A table write must never overtake a search still in the chain.
  `ASSERT_SAME(a_load_when_empty, load.en, busy_vec == '0, "load taken while chain busy")
  // A stalled result register freezes every token in the chain.
  `ASSERT_NEXT(a_chain_frozen, !advance, $stable(busy_vec), "chain moved while stalled")
  // A miss always reports the saturated rule count plus one.
  `ASSERT_SAME(a_miss_value, out_valid_q && !out_matched_q, out_num_q == miss_num,
               "miss result differs from count plus one")

endmodule

`default_nettype wire
